[rtl/int_to_ascii_formatter_macros.svh]
// Assertion macros for the integer-to-ASCII formatter.
// Included by the top level; no other dependencies.
`ifndef INT_TO_ASCII_FORMATTER_MACROS_SVH
`define INT_TO_ASCII_FORMATTER_MACROS_SVH

// Property checked on every clock edge, off while reset is held.
`define ITA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, off while reset is held.
`define ITA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ita_pkg.sv]
// Shared types, character codes and helpers of the integer-to-ASCII formatter.
// No dependencies.
`default_nettype none

package ita_pkg;

    // Digit count field; holds up to the 20 decimal digits of a 64-bit value.
    localparam int NdW = 5;

    localparam logic [1:0] RADIX_DEC    = 2'd0;
    localparam logic [1:0] RADIX_HEX_LO = 2'd1;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;

    typedef struct packed {
        logic           neg;
        logic           zero_pad;
        logic [1:0]     radix;
        logic [5:0]     min_width;
        logic [6:0]     room;
        logic [NdW-1:0] nd;
    } t_conv_info;

    // Digit slots needed to hold a value of vb bits in decimal or in hex.
    function automatic int num_digits(input int vb);
        int dec_n;
        int hex_n;
        dec_n = (vb * 1233) / 4096 + 1;
        hex_n = (vb + 3) / 4;
        return (dec_n > hex_n) ? dec_n : hex_n;
    endfunction

    // Map one digit to its character; any radix other than lower hex is upper case.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [1:0] radix);
        logic [7:0] base;
        base = (radix == RADIX_HEX_LO) ? CHAR_LO_A : CHAR_UP_A;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'd0, d};
        end
        return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

[rtl/ita_in_if.sv]
// Input channel of the integer-to-ASCII formatter: one value and its format.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ita_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic        signed_mode;
    logic [1:0]  radix_mode;
    logic        zero_pad;
    logic [5:0]  min_width;
    logic [6:0]  room;

    modport source (
        output valid, value_bits, signed_mode, radix_mode, zero_pad, min_width, room,
        input  ready
    );
    modport sink (
        input  valid, value_bits, signed_mode, radix_mode, zero_pad, min_width, room,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ita_out_if.sv]
// Output channel of the integer-to-ASCII formatter: one character per transfer.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, out_char, last, input ready);
    modport sink (input valid, out_char, last, output ready);
endinterface

`default_nettype wire

[rtl/ita_conv.sv]
// Digit converter: sign handling, bit-serial binary to BCD (shift and add 3)
// or direct nibble load for hex, then a serial strip of leading zero digits.
// Depends on ita_pkg.
`default_nettype none

module ita_conv #(
    parameter int VALUE_BITS = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [VALUE_BITS-1:0]         i_value,
    input  wire                          i_signed,
    input  wire [1:0]                    i_radix,
    input  wire                          i_zero_pad,
    input  wire [5:0]                    i_min_width,
    input  wire [6:0]                    i_room,
    output logic                         o_ready,
    input  wire                          i_take,
    output logic                         o_res_valid,
    output ita_pkg::t_conv_info          o_info,
    output logic [4*ita_pkg::num_digits(VALUE_BITS)-1:0] o_digits
);

    localparam int NumDigits = ita_pkg::num_digits(VALUE_BITS);
    localparam int DigW      = 4 * NumDigits;
    localparam int CntW      = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DAB   = 2'd1;
    localparam logic [1:0] S_STRIP = 2'd2;
    localparam logic [1:0] S_HOLD  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [DigW-1:0]       r_dig, n_dig;
    logic [CntW-1:0]       r_cnt, n_cnt;
    ita_pkg::t_conv_info   r_info, n_info;

    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;
    logic [DigW-1:0]       w_adj;
    logic [3:0]            w_top;

    assign w_neg = i_signed && i_value[VALUE_BITS-1];
    assign w_mag = w_neg ? (~i_value + 1'b1) : i_value;
    assign w_top = r_dig[DigW-1 -: 4];

    // Add 3 to every BCD digit of 5 or more ahead of the shift.
    always_comb begin
        for (int k = 0; k < NumDigits; k++) begin
            w_adj[4*k +: 4] = (r_dig[4*k +: 4] >= 4'd5) ? r_dig[4*k +: 4] + 4'd3
                                                         : r_dig[4*k +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_dig   = r_dig;
        n_cnt   = r_cnt;
        n_info  = r_info;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_info.neg       = w_neg;
                    n_info.zero_pad  = i_zero_pad;
                    n_info.radix     = i_radix;
                    n_info.min_width = i_min_width;
                    n_info.room      = i_room;
                    n_info.nd        = ita_pkg::NdW'(NumDigits);
                    if (i_radix == ita_pkg::RADIX_DEC) begin
                        n_mag   = w_mag;
                        n_dig   = '0;
                        n_cnt   = CntW'(VALUE_BITS);
                        n_state = S_DAB;
                    end else begin
                        n_dig   = DigW'(w_mag);
                        n_state = S_STRIP;
                    end
                end
            end
            S_DAB: begin
                n_dig = {w_adj[DigW-2:0], r_mag[VALUE_BITS-1]};
                n_mag = r_mag << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                // Drop one leading zero digit per cycle, keep at least one digit.
                if ((r_info.nd > ita_pkg::NdW'(1)) && (w_top == 4'd0)) begin
                    n_dig     = r_dig << 4;
                    n_info.nd = r_info.nd - 1'b1;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag  <= n_mag;
        r_dig  <= n_dig;
        r_cnt  <= n_cnt;
        r_info <= n_info;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_HOLD);
    assign o_info      = r_info;
    assign o_digits    = r_dig;

endmodule

`default_nettype wire

[rtl/ita_emit.sv]
// Character emitter: sends minus, padding and digits one per cycle while not
// stalled, via an output register, cut to the room (at most MAX_ROOM). Needs ita_pkg.
`default_nettype none

module ita_emit #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_ROOM   = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_res_valid,
    input  ita_pkg::t_conv_info          i_info,
    input  wire [4*ita_pkg::num_digits(VALUE_BITS)-1:0] i_digits,
    output logic                         o_take,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [7:0]                   o_char,
    output logic                         o_last
);

    localparam int DigW = 4 * ita_pkg::num_digits(VALUE_BITS);

    logic            r_busy, n_busy;
    logic            r_valid, n_valid;
    logic [7:0]      r_char, n_char;
    logic            r_last, n_last;
    logic            r_neg, n_neg;
    logic            r_pad_zero, n_pad_zero;
    logic [1:0]      r_radix, n_radix;
    logic [5:0]      r_pad, n_pad;
    logic [6:0]      r_left, n_left;
    logic [DigW-1:0] r_dig, n_dig;

    logic       w_step;
    logic [5:0] w_pad;
    logic [6:0] w_len;
    logic [6:0] w_lim;
    logic [6:0] w_left;

    assign o_take = i_res_valid && !r_busy;
    assign w_step = r_busy && (!r_valid || i_ready);

    assign w_pad  = (i_info.min_width > {1'b0, i_info.nd})
                  ? i_info.min_width - {1'b0, i_info.nd} : 6'd0;
    assign w_len  = 7'(i_info.neg) + 7'(w_pad) + 7'(i_info.nd);
    assign w_lim  = (i_info.room > 7'(MAX_ROOM)) ? 7'(MAX_ROOM) : i_info.room;
    assign w_left = (w_len > w_lim) ? w_lim : w_len;

    always_comb begin
        n_busy     = r_busy;
        n_valid    = r_valid;
        n_char     = r_char;
        n_last     = r_last;
        n_neg      = r_neg;
        n_pad_zero = r_pad_zero;
        n_radix    = r_radix;
        n_pad      = r_pad;
        n_left     = r_left;
        n_dig      = r_dig;

        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end

        if (o_take) begin
            n_neg      = i_info.neg;
            n_pad_zero = i_info.zero_pad;
            n_radix    = i_info.radix;
            n_pad      = w_pad;
            n_dig      = i_digits;
            n_left     = w_left;
            n_busy     = (w_left != 7'd0);
        end else if (w_step) begin
            n_valid = 1'b1;
            n_last  = (r_left == 7'd1);
            n_left  = r_left - 1'b1;
            if (r_left == 7'd1) begin
                n_busy = 1'b0;
            end
            priority if (r_neg) begin
                n_char = ita_pkg::CHAR_MINUS;
                n_neg  = 1'b0;
            end else if (r_pad != 6'd0) begin
                n_char = r_pad_zero ? ita_pkg::CHAR_ZERO : ita_pkg::CHAR_SPACE;
                n_pad  = r_pad - 1'b1;
            end else begin
                n_char = ita_pkg::digit_char(r_dig[DigW-1 -: 4], r_radix);
                n_dig  = r_dig << 4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
        r_char     <= n_char;
        r_last     <= n_last;
        r_neg      <= n_neg;
        r_pad_zero <= n_pad_zero;
        r_radix    <= n_radix;
        r_pad      <= n_pad;
        r_left     <= n_left;
        r_dig      <= n_dig;
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[rtl/int_to_ascii_formatter.sv]
// Integer-to-ASCII formatter top level: digit converter feeding a character emitter.
// Depends on ita_pkg, ita_in_if, ita_out_if, ita_conv, ita_emit and the macro header.
//
// Usage:
//   i_in carries one request: a value (low VALUE_BITS bits used), signed mode,
//   radix (decimal, lower hex, upper hex), pad character choice, minimum digit
//   width and the room left. o_out returns the text one character per transfer,
//   with last set on the final one; room zero yields no characters at all.
//   Decimal conversion shifts one value bit per cycle through a BCD register;
//   hex loads the nibbles directly. Leading zero digits are then stripped one per
//   cycle (up to 19 for 64 bits, at least 4 in hex), and the result is held until
//   the emitter, once it has issued its previous text, takes it. Each character
//   passes through the emitter's output register; after the first, one character
//   per cycle follows while the receiver does not stall. The next request can be
//   accepted in the cycle after the converter hands its result to the emitter, so
//   its conversion overlaps the current output. A stalled receiver holds the
//   output register; the emitter waits behind it. Reset (synchronous, active
//   low) empties both stages.
`default_nettype none

`include "int_to_ascii_formatter_macros.svh"

module int_to_ascii_formatter #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_ROOM   = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ita_in_if.sink     i_in,
    ita_out_if.source  o_out
);

    localparam int DigW = 4 * ita_pkg::num_digits(VALUE_BITS);

    logic                w_conv_ready;
    logic                w_res_valid;
    logic                w_take;
    ita_pkg::t_conv_info w_info;
    logic [DigW-1:0]     w_digits;
    logic                w_valid;
    logic [7:0]          w_char;
    logic                w_last;

    ita_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && w_conv_ready),
        .i_value     (i_in.value_bits[VALUE_BITS-1:0]),
        .i_signed    (i_in.signed_mode),
        .i_radix     (i_in.radix_mode),
        .i_zero_pad  (i_in.zero_pad),
        .i_min_width (i_in.min_width),
        .i_room      (i_in.room),
        .o_ready     (w_conv_ready),
        .i_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_info      (w_info),
        .o_digits    (w_digits)
    );

    ita_emit #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ROOM   (MAX_ROOM)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_info      (w_info),
        .i_digits    (w_digits),
        .o_take      (w_take),
        .o_valid     (w_valid),
        .i_ready     (o_out.ready),
        .o_char      (w_char),
        .o_last      (w_last)
    );

    assign i_in.ready     = w_conv_ready;
    assign o_out.valid    = w_valid;
    assign o_out.out_char = w_char;
    assign o_out.last     = w_last;

    `ITA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "converter still ready after a request")
    `ITA_ASSERT_NEXT(a_release_on_take, i_clk, i_rst_n, w_take, !w_res_valid, "converter result held after hand-off")
    `ITA_ASSERT_NEXT(a_no_gap_in_text, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last, o_out.valid, "gap inside one item's text")
    `ITA_ASSERT(a_char_nonzero, i_clk, i_rst_n, !o_out.valid || (o_out.out_char != 8'h00), "null character emitted")

endmodule

`default_nettype wire

[sim/tb_int_to_ascii_formatter.sv]
// Self-checking testbench for int_to_ascii_formatter: drives format requests and checks
// every emitted character and last flag against a behavioral formatter kept here.
// Depends on ita_pkg, ita_in_if, ita_out_if and the RTL top level.
module tb_int_to_ascii_formatter;

    localparam logic [1:0] RADIX_HEX_UP = 2'd2;
    localparam logic [1:0] RADIX_ODD    = 2'd3;  // fourth selector code, upper-case hex
    localparam int MAX_CHARS    = 64;
    localparam int SETTLE_CYCLES = 150;          // covers a decimal conversion with no text
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef struct packed {
        logic [63:0] value;
        logic        sgn;
        logic [1:0]  radix;
        logic        zpad;
        logic [5:0]  width;
        logic [6:0]  room;
    } t_fmt_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    ita_in_if  in_ch ();
    ita_out_if out_ch ();

    int_to_ascii_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_text_char expected_chars[$];
    bit  idling_on;
    int  error_count;
    int  requests_sent;
    int  empty_requests;
    int  chars_checked;
    int  cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d characters outstanding",
                     $time, cycle_count, expected_chars.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Expected text for one request: sign, padding, digits, then cut to the room.
    function automatic void format_text(input t_fmt_req r);
        logic [63:0] mag;
        logic [7:0]  rev  [0:23];
        logic [7:0]  text [0:127];
        logic [7:0]  letter_base;
        logic [7:0]  pad_char;
        logic [3:0]  d;
        logic        neg;
        t_text_char  tc;
        int nd;
        int len;
        int cap;
        int i;
        neg         = r.sgn && r.value[63];
        mag         = neg ? (~r.value + 64'd1) : r.value;
        letter_base = (r.radix == ita_pkg::RADIX_HEX_LO) ? ita_pkg::CHAR_LO_A
                                                         : ita_pkg::CHAR_UP_A;
        pad_char    = r.zpad ? ita_pkg::CHAR_ZERO : ita_pkg::CHAR_SPACE;
        nd = 0;
        if (r.radix == ita_pkg::RADIX_DEC) begin
            do begin
                d = 4'(mag % 64'd10);
                rev[nd] = ita_pkg::CHAR_ZERO + {4'd0, d};
                nd = nd + 1;
                mag = mag / 64'd10;
            end while (mag != 64'd0);
        end else begin
            do begin
                d = mag[3:0];
                rev[nd] = (d < 4'd10) ? ita_pkg::CHAR_ZERO + {4'd0, d}
                                      : letter_base + {4'd0, d} - 8'd10;
                nd = nd + 1;
                mag = mag >> 4;
            end while (mag != 64'd0);
        end
        len = 0;
        if (neg) begin
            text[len] = ita_pkg::CHAR_MINUS;
            len = len + 1;
        end
        for (i = nd; i < int'(r.width); i++) begin
            text[len] = pad_char;
            len = len + 1;
        end
        for (i = nd - 1; i >= 0; i--) begin
            text[len] = rev[i];
            len = len + 1;
        end
        cap = (int'(r.room) > MAX_CHARS) ? MAX_CHARS : int'(r.room);
        if (len > cap) begin
            len = cap;
        end
        for (i = 0; i < len; i++) begin
            tc.ch   = text[i];
            tc.last = (i == len - 1);
            expected_chars.push_back(tc);
        end
    endfunction

    function automatic t_fmt_req make_req(input logic [63:0] value, input logic sgn,
                                          input logic [1:0] radix, input logic zpad,
                                          input logic [5:0] width, input logic [6:0] room);
        t_fmt_req r;
        r.value = value;
        r.sgn   = sgn;
        r.radix = radix;
        r.zpad  = zpad;
        r.width = width;
        r.room  = room;
        return r;
    endfunction

    function automatic t_fmt_req random_req();
        t_fmt_req r;
        case ($urandom_range(0, 7))
            0: r.value = 64'($urandom_range(0, 1000));
            1: r.value = -64'($urandom_range(1, 1000));
            2: r.value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            3: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
            4: begin
                case ($urandom_range(0, 3))
                    0: r.value = 64'd0;
                    1: r.value = 64'hFFFF_FFFF_FFFF_FFFF;
                    2: r.value = 64'h8000_0000_0000_0000;
                    default: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            default: r.value = {$urandom, $urandom};
        endcase
        r.sgn   = 1'($urandom_range(0, 1));
        r.radix = 2'($urandom_range(0, 3));
        r.zpad  = 1'($urandom_range(0, 1));
        r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 24));
        case ($urandom_range(0, 15))
            0: r.room = 7'd0;
            1: r.room = 7'($urandom_range(65, 127));
            default: r.room = 7'($urandom_range(1, 64));
        endcase
        return r;
    endfunction

    // Present one request, hold it until accepted, then record its text.
    task automatic send_request(input t_fmt_req r);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.value_bits  <= r.value;
        in_ch.signed_mode <= r.sgn;
        in_ch.radix_mode  <= r.radix;
        in_ch.zero_pad    <= r.zpad;
        in_ch.min_width   <= r.width;
        in_ch.room        <= r.room;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        format_text(r);
        requests_sent = requests_sent + 1;
        if (r.room == 7'd0) begin
            empty_requests = empty_requests + 1;
        end
    endtask

    // Hold off new requests until all expected text has come out.
    task automatic drain_output();
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stall bursts while idling is on.
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compare every accepted character with the oldest expected one.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got 0x%02h last=%0b",
                         $time, out_ch.out_char, out_ch.last);
                error_count = error_count + 1;
            end else begin
                want = expected_chars.pop_front();
                chars_checked = chars_checked + 1;
                if (out_ch.out_char !== want.ch) begin
                    $display("%0t: out_char mismatch: expected 0x%02h, got 0x%02h",
                             $time, want.ch, out_ch.out_char);
                    error_count = error_count + 1;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, out_ch.last);
                    error_count = error_count + 1;
                end
            end
        end
    end

    task automatic test_directed_cases();
        t_fmt_req reqs[$];
        reqs.push_back(make_req(64'd0, 1'b0, ita_pkg::RADIX_DEC, 1'b0, 6'd0, 7'd64));
        reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ita_pkg::RADIX_DEC, 1'b0,
                                6'd0, 7'd64));
        reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ita_pkg::RADIX_DEC, 1'b0,
                                6'd0, 7'd64));
        // most negative value prints its full magnitude
        reqs.push_back(make_req(64'h8000_0000_0000_0000, 1'b1, ita_pkg::RADIX_DEC, 1'b0,
                                6'd0, 7'd64));
        reqs.push_back(make_req(64'h8000_0000_0000_0000, 1'b1, ita_pkg::RADIX_HEX_LO, 1'b0,
                                6'd0, 7'd64));
        reqs.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ita_pkg::RADIX_DEC, 1'b1,
                                6'd25, 7'd64));
        reqs.push_back(make_req(64'hDEAD_BEEF_CAFE_F00D, 1'b0, ita_pkg::RADIX_HEX_LO, 1'b0,
                                6'd0, 7'd64));
        reqs.push_back(make_req(64'hDEAD_BEEF_CAFE_F00D, 1'b0, RADIX_HEX_UP, 1'b0,
                                6'd0, 7'd64));
        reqs.push_back(make_req(64'h0123_4567_89AB_CDEF, 1'b0, RADIX_ODD, 1'b0, 6'd0, 7'd64));
        // signed hex: minus plus hex magnitude
        reqs.push_back(make_req(-64'd255, 1'b1, ita_pkg::RADIX_HEX_LO, 1'b1, 6'd6, 7'd64));
        reqs.push_back(make_req(-64'd42, 1'b1, ita_pkg::RADIX_DEC, 1'b1, 6'd8, 7'd64));
        reqs.push_back(make_req(-64'd42, 1'b1, ita_pkg::RADIX_DEC, 1'b0, 6'd8, 7'd64));
        reqs.push_back(make_req(64'd12345, 1'b0, ita_pkg::RADIX_DEC, 1'b0, 6'd63, 7'd64));
        reqs.push_back(make_req(-64'd7, 1'b1, ita_pkg::RADIX_DEC, 1'b1, 6'd63, 7'd127));
        reqs.push_back(make_req(64'd123456, 1'b0, ita_pkg::RADIX_DEC, 1'b1, 6'd3, 7'd64));
        reqs.push_back(make_req(64'd98765, 1'b0, ita_pkg::RADIX_DEC, 1'b0, 6'd0, 7'd1));
        reqs.push_back(make_req(64'd98765, 1'b0, ita_pkg::RADIX_DEC, 1'b0, 6'd0, 7'd0));
        reqs.push_back(make_req(64'hABC, 1'b0, RADIX_HEX_UP, 1'b0, 6'd0, 7'd0));
        reqs.push_back(make_req(-64'd98765, 1'b1, ita_pkg::RADIX_DEC, 1'b0, 6'd0, 7'd3));
        reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ita_pkg::RADIX_DEC, 1'b1,
                                6'd40, 7'd65));
        reqs.push_back(make_req(64'd5, 1'b1, ita_pkg::RADIX_HEX_LO, 1'b1, 6'd63, 7'd127));
        reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ita_pkg::RADIX_HEX_LO, 1'b1,
                                6'd0, 7'd16));
        reqs.push_back(make_req(64'd0, 1'b1, RADIX_ODD, 1'b1, 6'd63, 7'd64));
        foreach (reqs[i]) send_request(reqs[i]);
    endtask

    task automatic test_random_formats();
        int n;
        for (n = 0; n < 300; n++) begin
            // switch between stretches with and without idling
            if (n % 40 == 0) begin
                idling_on = ($urandom_range(0, 3) != 0);
            end
            if (n == 150) begin
                drain_output();
            end
            send_request(random_req());
        end
    endtask

    task automatic test_full_rate();
        int n;
        idling_on = 1'b0;
        for (n = 0; n < 50; n++) begin
            send_request(random_req());
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.value_bits  <= 64'd0;
        in_ch.signed_mode <= 1'b0;
        in_ch.radix_mode  <= ita_pkg::RADIX_DEC;
        in_ch.zero_pad    <= 1'b0;
        in_ch.min_width   <= 6'd0;
        in_ch.room        <= 7'd0;
        idling_on      = 1'b1;
        error_count    = 0;
        requests_sent  = 0;
        empty_requests = 0;
        chars_checked  = 0;
        cycle_count    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        drain_output();
        test_random_formats();
        drain_output();
        test_full_rate();
        drain_output();
        $display("Formatted %0d requests (%0d with no room) across all radix, sign and pad modes;",
                 requests_sent, empty_requests);
        $display("%0d characters checked with random stalls on both channels.", chars_checked);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
